[hdl/mnsv_pkg.sv]
// Shared types and codes of the MUP NLRI stream validator.
package mnsv_pkg;

    localparam logic [7:0]  ARCH_5G    = 8'd1;
    localparam logic [15:0] KIND_ISD   = 16'd1;
    localparam logic [15:0] KIND_DSD   = 16'd2;
    localparam logic [15:0] KIND_T1ST  = 16'd3;
    localparam logic [15:0] KIND_T2ST  = 16'd4;
    localparam logic [7:0]  TLV_SESSION   = 8'd1;
    localparam logic [7:0]  TLV_INTERWORK = 8'd2;
    localparam logic [7:0]  TLV_SOURCE    = 8'd3;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_PATH     = 3'd1;
    localparam logic [2:0] PH_HDR      = 3'd2;
    localparam logic [2:0] PH_BODY     = 3'd3;
    localparam logic [2:0] PH_TLV_TYPE = 3'd4;
    localparam logic [2:0] PH_TLV_LEN  = 3'd5;
    localparam logic [2:0] PH_TLV_VAL  = 3'd6;

    localparam logic [1:0] RS_UPDATE   = 2'd0;
    localparam logic [1:0] RS_WITHDRAW = 2'd1;
    localparam logic [1:0] RS_BAD      = 2'd2;
    localparam logic [1:0] RS_IGNORED  = 2'd3;

    localparam logic [1:0] PS_OK       = 2'd0;
    localparam logic [1:0] PS_OVERFLOW = 2'd1;
    localparam logic [1:0] PS_NO_HDR   = 2'd2;

    localparam logic [7:0] CFG_IPV6    = 8'd0;
    localparam logic [7:0] CFG_PATH_ID = 8'd1;

    localparam int OUT_DATA_W = 296;

    typedef struct packed {
        logic ipv6;
        logic path_id;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  flow_id;
        logic [31:0] tunnel_id;
        logic [7:0]  bit_length;
        logic [63:0] addr_lower;
        logic [63:0] addr_upper;
        logic [63:0] dist_value;
        logic [31:0] path_ident;
        logic [15:0] route_kind;
        logic [1:0]  route_status;
    } t_route;

    typedef struct packed {
        logic       route_v;
        t_route     route;
        logic       pkt_v;
        logic [1:0] pkt_status;
    } t_emit;

endpackage

[hdl/mup_nlri_stream_validator_unit.sv]
// Top level of the MUP NLRI stream validator.
//
// Slave stream: one NLRI byte per item in s_axis_tdata, tlast marks the
// last byte of the region, tuser flags a withdraw list.
// Master stream: one verdict per item. tuser high is the packet verdict,
// low a route verdict carrying the route key fields.
// Config channel: i_cfg_valid/o_cfg_ready with an index (0 IPv6 family,
// 1 path id present) and one data bit; always ready; the user must make idle writes only, the block does not check it.
// Output: a verdict is registered and appears in the cycle after the byte that causes it.
// Throughput: one byte per cycle while the receiver takes each verdict;
// a byte ending both a route and the region yields two verdicts and holds
// the input until the route verdict is taken from the register pair.
// Reset: parser returns to the start of a route, no verdicts pending,
// config bits cleared; the output registers keep their data.
// Stall: while the receiver holds tready low, pending verdicts stay and
// s_axis_tready drops once no room is left.
module mup_nlri_stream_validator_unit import mnsv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // data_byte
    input  logic                  s_axis_tlast,   // last_byte
    input  logic                  s_axis_tuser,   // withdraw_pkt
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // route_status, packet_status, route_kind, path_ident, dist_value,
    // addr_upper, addr_lower, bit_length, tunnel_id, flow_id, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tuser,   // packet_end
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [7:0]            i_cfg_index,
    input  logic                  i_cfg_data
);
    t_cfg  r_cfg;
    t_emit emit;
    logic  accept;

    assign o_cfg_ready = 1'b1;
    assign accept = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IPV6)    r_cfg.ipv6    <= i_cfg_data;
            if (i_cfg_index == CFG_PATH_ID) r_cfg.path_id <= i_cfg_data;
        end
    end

    mnsv_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_wd     (s_axis_tuser),
        .o_emit   (emit)
    );

    mnsv_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_emit  (emit),
        .o_space (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser)
    );
endmodule

[hdl/mnsv_parser.sv]
// Byte-wise route parser: state registers and the per-byte next-state and verdict logic.
module mnsv_parser import mnsv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_wd,
    output t_emit      o_emit
);
    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_idx, n_idx, r_bsz, n_bsz, r_arch, n_arch;
    logic [15:0] r_kind, n_kind;
    logic [31:0] r_path, n_path, r_teid, n_teid;
    logic [63:0] r_dist, n_dist;
    logic [7:0]  r_addr [16];
    logic [7:0]  n_addr [16];
    logic [7:0]  r_len0, n_len0, r_len1, n_len1, r_len2, n_len2, r_rem, n_rem;
    logic        r_bad, n_bad;

    logic        idle, known, bad, emit;
    logic [9:0]  o, po, a, maxb, m, k, j, sz;
    logic [5:0]  tb;
    logic [31:0] t2teid;
    logic [1:0]  st, ps;
    logic [127:0] addr_flat;

    always_comb begin
        idle = (r_phase == PH_IDLE);
        n_phase = r_phase;
        n_idx  = idle ? 8'd0  : r_idx;
        n_bsz  = idle ? 8'd0  : r_bsz;
        n_arch = idle ? 8'd0  : r_arch;
        n_kind = idle ? 16'd0 : r_kind;
        n_path = idle ? 32'd0 : r_path;
        n_teid = idle ? 32'd0 : r_teid;
        n_dist = idle ? 64'd0 : r_dist;
        for (int i = 0; i < 16; i++) n_addr[i] = idle ? 8'd0 : r_addr[i];
        n_len0 = idle ? 8'd0 : r_len0;
        n_len1 = idle ? 8'd0 : r_len1;
        n_len2 = idle ? 8'd0 : r_len2;
        n_rem  = idle ? 8'd0 : r_rem;
        n_bad  = idle ? 1'b0 : r_bad;
        if (idle) n_phase = i_cfg.path_id ? PH_PATH : PH_HDR;
        a    = i_cfg.ipv6 ? 10'd16 : 10'd4;
        maxb = i_cfg.ipv6 ? 10'd128 : 10'd32;
        o    = {2'b0, n_idx};
        known = (n_arch == ARCH_5G) && (n_kind >= KIND_ISD) && (n_kind <= KIND_T2ST);
        po = 10'd0;
        m  = 10'd0;
        k  = 10'd0;
        j  = 10'd0;
        emit = 1'b0;

        if (n_phase == PH_PATH) begin
            n_path = {n_path[23:0], i_byte};
            n_idx = n_idx + 8'd1;
            if (n_idx == 8'd4) begin
                n_idx = 8'd0;
                n_phase = PH_HDR;
            end
        end else if (n_phase == PH_HDR) begin
            unique case (n_idx[1:0])
                2'd0: n_arch = i_byte;
                2'd1: n_kind = {i_byte, 8'd0};
                2'd2: n_kind = {n_kind[15:8], i_byte};
                default: n_bsz = i_byte;
            endcase
            n_idx = n_idx + 8'd1;
            if (n_idx == 8'd4) begin
                n_idx = 8'd0;
                n_phase = PH_BODY;
                if (n_bsz == 8'd0) emit = 1'b1;
            end
        end else begin
            if (n_phase == PH_BODY) begin
                if (o < 10'd8) begin
                    n_dist = {n_dist[55:0], i_byte};
                end else if (known) begin
                    if (n_kind == KIND_ISD) begin
                        if (o == 10'd8) begin
                            n_len0 = i_byte;
                            if ({2'b0, i_byte} > maxb) n_bad = 1'b1;
                        end else k = o - 10'd9;
                        if (o != 10'd8 && k < 10'd16) n_addr[k[3:0]] = n_addr[k[3:0]] | i_byte;
                    end else if (n_kind == KIND_DSD) begin
                        k = o - 10'd8;
                        if (k < 10'd16) n_addr[k[3:0]] = n_addr[k[3:0]] | i_byte;
                    end else if (n_kind == KIND_T1ST) begin
                        if (o == 10'd8) begin
                            n_len0 = i_byte;
                            if ({2'b0, i_byte} > maxb) n_bad = 1'b1;
                        end else begin
                            po = ({2'b0, n_len0} + 10'd7) >> 3;
                            if (o < 10'd9 + po) begin
                                k = o - 10'd9;
                                if (k < 10'd16) n_addr[k[3:0]] = n_addr[k[3:0]] | i_byte;
                            end else if (o < 10'd13 + po) begin
                                n_teid = {n_teid[23:0], i_byte};
                                if (o == 10'd12 + po && n_teid == 32'd0) n_bad = 1'b1;
                            end else if (o == 10'd13 + po) begin
                                n_len1 = i_byte;
                            end else if (o == 10'd14 + po) begin
                                if ({2'b0, i_byte} != maxb) n_bad = 1'b1;
                            end else if (o == 10'd15 + po + a) begin
                                n_len2 = i_byte;
                                if (i_byte != 8'd0 && {2'b0, i_byte} != maxb) n_bad = 1'b1;
                            end
                            if (o >= 10'd15 + po + a) begin
                                m = 10'd16 + po + a + ((n_len2 != 8'd0) ? a : 10'd0);
                                if (o + 10'd1 == m) n_phase = PH_TLV_TYPE;
                            end
                        end
                    end else begin
                        if (o == 10'd8) begin
                            n_len0 = i_byte;
                            if ({2'b0, i_byte} > maxb + 10'd32) n_bad = 1'b1;
                        end else if (o < 10'd9 + a) begin
                            k = o - 10'd9;
                            n_addr[k[3:0]] = n_addr[k[3:0]] | i_byte;
                        end else begin
                            j = o - 10'd9 - a;
                            if (j < 10'd4)
                                n_teid = n_teid | ({i_byte, 24'd0} >> {j[1:0], 3'b000});
                        end
                    end
                end
            end else if (n_phase == PH_TLV_TYPE) begin
                n_len2 = i_byte;
                n_phase = PH_TLV_LEN;
            end else if (n_phase == PH_TLV_LEN) begin
                n_rem = i_byte;
                if (n_kind == KIND_T2ST) begin
                    if (n_len2 == TLV_SESSION && i_byte != 8'd5) n_bad = 1'b1;
                    if ((n_len2 == TLV_INTERWORK || n_len2 == TLV_SOURCE)
                        && i_byte != 8'd4 && i_byte != 8'd16) n_bad = 1'b1;
                end
                n_phase = (i_byte != 8'd0) ? PH_TLV_VAL : PH_TLV_TYPE;
            end else begin
                n_rem = n_rem - 8'd1;
                if (n_rem == 8'd0) n_phase = PH_TLV_TYPE;
            end
            n_idx = n_idx + 8'd1;
            if (n_idx == n_bsz) emit = 1'b1;
        end

        // T2ST TEID width and masked value
        if ({2'b0, n_len0} > {a[6:0], 3'b000})
            tb = ({2'b0, n_len0} - {a[6:0], 3'b000} > 10'd32) ? 6'd32
               : 6'({2'b0, n_len0} - {a[6:0], 3'b000});
        else
            tb = 6'd0;
        t2teid = n_teid & ~(32'hFFFF_FFFF >> tb);
        if (r_phase == PH_BODY && n_phase == PH_BODY && known && n_kind == KIND_T2ST
            && o >= 10'd8) begin
            m = 10'd9 + a + ((10'({4'b0, tb}) + 10'd7) >> 3);
            if (o + 10'd1 == m) n_phase = PH_TLV_TYPE;
        end else if (idle == 1'b0 && 1'b0) begin
            n_phase = r_phase;
        end

        sz = {2'b0, n_bsz};
        bad = n_bad;
        if (n_kind == KIND_ISD) begin
            if (sz < 10'd9 || sz - 10'd9 != (({2'b0, n_len0} + 10'd7) >> 3)) bad = 1'b1;
        end else if (n_kind == KIND_DSD) begin
            if (sz != 10'd8 + a) bad = 1'b1;
        end else begin
            if (n_phase != PH_TLV_TYPE) bad = 1'b1;
            if (n_kind == KIND_T2ST && tb != 6'd0 && t2teid == 32'd0) bad = 1'b1;
        end
        if (!known)   st = RS_IGNORED;
        else if (bad) st = RS_BAD;
        else          st = i_wd ? RS_WITHDRAW : RS_UPDATE;

        for (int i = 0; i < 16; i++) addr_flat[127 - 8*i -: 8] = n_addr[i];

        o_emit.route_v = emit;
        o_emit.route.route_status = st;
        o_emit.route.route_kind   = n_kind;
        o_emit.route.path_ident   = n_path;
        o_emit.route.dist_value   = st[1] ? 64'd0 : n_dist;
        o_emit.route.addr_upper   = st[1] ? 64'd0 : addr_flat[127:64];
        o_emit.route.addr_lower   = st[1] ? 64'd0 : addr_flat[63:0];
        o_emit.route.bit_length   = (st[1] || n_kind == KIND_DSD) ? 8'd0 : n_len0;
        o_emit.route.tunnel_id    = st[1] ? 32'd0
                                  : (n_kind == KIND_T1ST) ? n_teid
                                  : (n_kind == KIND_T2ST) ? t2teid : 32'd0;
        o_emit.route.flow_id      = (!st[1] && n_kind == KIND_T1ST) ? n_len1 : 8'd0;

        if (emit) n_phase = PH_IDLE;
        if (n_phase == PH_IDLE)     ps = PS_OK;
        else if (n_phase == PH_HDR) ps = PS_NO_HDR;
        else                        ps = PS_OVERFLOW;
        o_emit.pkt_v = i_last;
        o_emit.pkt_status = ps;
        if (i_last) n_phase = PH_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_accept) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_idx  <= n_idx;
            r_bsz  <= n_bsz;
            r_arch <= n_arch;
            r_kind <= n_kind;
            r_path <= n_path;
            r_teid <= n_teid;
            r_dist <= n_dist;
            r_addr <= n_addr;
            r_len0 <= n_len0;
            r_len1 <= n_len1;
            r_len2 <= n_len2;
            r_rem  <= n_rem;
            r_bad  <= n_bad;
        end
    end
endmodule

[hdl/mnsv_out_buf.sv]
// Two-slot result register: route verdict then packet verdict, one item per cycle out while the receiver is ready.
module mnsv_out_buf import mnsv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  t_emit                 i_emit,
    output logic                  o_space,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_DATA_W-1:0] o_data,
    output logic                  o_user
);
    logic       r_route_v, n_route_v, r_pkt_v, n_pkt_v;
    t_route     r_route;
    logic [1:0] r_pkt_st;
    logic       pop;
    t_route     shown;

    assign o_valid = r_route_v | r_pkt_v;
    assign pop     = o_valid & i_ready;
    assign o_space = !o_valid || (pop && (r_route_v ^ r_pkt_v));

    always_comb begin
        shown = r_route;
        if (!r_route_v) begin
            shown = '0;
            shown.route_status = RS_UPDATE;
        end
        o_user = !r_route_v;
        o_data = {4'b0, shown.flow_id, shown.tunnel_id, shown.bit_length,
                  shown.addr_lower, shown.addr_upper, shown.dist_value,
                  shown.path_ident, shown.route_kind,
                  (r_route_v ? PS_OK : r_pkt_st), shown.route_status};
        n_route_v = r_route_v;
        n_pkt_v   = r_pkt_v;
        if (pop) begin
            if (r_route_v) n_route_v = 1'b0;
            else           n_pkt_v   = 1'b0;
        end
        if (i_load) begin
            n_route_v = i_emit.route_v;
            n_pkt_v   = i_emit.pkt_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_route_v <= 1'b0;
            r_pkt_v   <= 1'b0;
        end else begin
            r_route_v <= n_route_v;
            r_pkt_v   <= n_pkt_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_route  <= i_emit.route;
            r_pkt_st <= i_emit.pkt_status;
        end
    end
endmodule
